### rtl/mrt_pkg.sv
// Package for the 64-bit Miller-Rabin prime tester.
// Holds widths, size limits, base tables and the controller/datapath link types.
`timescale 1ns / 1ps

package mrt_pkg;

    localparam int unsigned XW   = 64;
    localparam int unsigned BW   = 31;
    localparam int unsigned IDXW = 3;
    localparam int unsigned SW   = 6;

    localparam logic [XW-1:0] SMALL_LIMIT = 64'd316349281;
    localparam logic [XW-1:0] MID_LIMIT   = 64'd4759123141;

    typedef enum logic [1:0] {
        SET_SMALL = 2'd0,
        SET_MID   = 2'd1,
        SET_LARGE = 2'd2
    } t_set;

    // operand selection of the shared modular multiplier
    typedef enum logic [1:0] {
        MOP_REDUCE = 2'd0,   // 1 * base mod x
        MOP_RB     = 2'd1,   // t * b mod x
        MOP_BB     = 2'd2,   // b * b mod x
        MOP_TT     = 2'd3    // t * t mod x
    } t_mop;

    typedef struct packed {
        logic load;
        logic shift_d;
        logic mul_start;
        t_mop mop;
        logic k_init;
        logic idx_inc;
        logic out_write;
        logic out_val;
    } t_cmd;

    typedef struct packed {
        logic below4;
        logic gt1;
        logic even;
        logic d_odd;
        logic b_zero;
        logic e_zero;
        logic e_lsb;
        logic t_pass;
        logic t_xm1;
        logic t_le1;
        logic k_done;
        logic last_base;
        logic mul_done;
        logic out_free;
    } t_sts;

    function automatic logic [BW-1:0] base_at(input t_set set, input logic [IDXW-1:0] idx);
        logic [BW-1:0] v;
        v = '0;
        case (set)
            SET_SMALL: begin
                case (idx)
                    3'd0:    v = 31'd11000544;
                    default: v = 31'd31481107;
                endcase
            end
            SET_MID: begin
                case (idx)
                    3'd0:    v = 31'd2;
                    3'd1:    v = 31'd7;
                    default: v = 31'd61;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    v = 31'd2;
                    3'd1:    v = 31'd325;
                    3'd2:    v = 31'd9375;
                    3'd3:    v = 31'd28178;
                    3'd4:    v = 31'd450775;
                    3'd5:    v = 31'd9780504;
                    default: v = 31'd1795265022;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [IDXW-1:0] last_idx(input t_set set);
        logic [IDXW-1:0] v;
        case (set)
            SET_SMALL: v = 3'd1;
            SET_MID:   v = 3'd2;
            default:   v = 3'd6;
        endcase
        return v;
    endfunction

endpackage

### rtl/mrt_if.sv
// Valid/ready channel interfaces for candidate and verdict words.
// Depends on mrt_pkg for the candidate width.
`timescale 1ns / 1ps

interface mrt_in_if import mrt_pkg::*;;
    logic          valid;
    logic          ready;
    logic [XW-1:0] candidate;
    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface mrt_out_if;
    logic valid;
    logic ready;
    logic prime;
    modport source (output valid, output prime, input ready);
    modport sink   (input valid, input prime, output ready);
endinterface

### rtl/mrt_mulmod.sv
// Bit-serial exact modular multiplier: r = a * b mod m, one bit of b per cycle.
// Needs a < m and m >= 2; depends on mrt_pkg.
`timescale 1ns / 1ps

module mrt_mulmod import mrt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [XW-1:0] i_a,
    input  logic [XW-1:0] i_b,
    input  logic [XW-1:0] i_m,
    output logic          o_done,
    output logic [XW-1:0] o_r
);

    logic [XW-1:0] r_a, r_b, r_m, r_r;
    logic [SW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [XW-1:0] n_dbl, n_r, room1, room2;

    // double then conditionally add, both modulo m without overflow
    always_comb begin
        room1 = r_m - r_r;
        n_dbl = (r_r >= room1) ? (r_r - room1) : (r_r + r_r);
        room2 = r_m - r_a;
        if (r_b[XW-1]) begin
            n_r = (n_dbl >= room2) ? (n_dbl - room2) : (n_dbl + r_a);
        end else begin
            n_r = n_dbl;
        end
    end

    // control: run for one pass over the multiplier bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == SW'(XW-1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(XW-1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: hold operands, advance the accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            r_b <= {r_b[XW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

endmodule

### rtl/mrt_dp.sv
// Datapath of the prime tester: candidate, exponent split, power and witness registers.
// Depends on mrt_pkg and mrt_mulmod.
`timescale 1ns / 1ps

module mrt_dp import mrt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [XW-1:0] i_candidate,
    input  logic          i_out_ready,
    output t_sts          o_sts,
    output logic          o_out_valid,
    output logic          o_prime
);

    logic [XW-1:0]   r_x, r_xm1, r_d, r_e, r_b, r_t;
    logic [SW-1:0]   r_s, r_k;
    logic [IDXW-1:0] r_idx;
    t_mop            r_mop;
    logic            r_out_valid, r_out_prime;

    t_set            set;
    logic [XW-1:0]   mul_a, mul_b, mul_r;
    logic            mul_done;

    // pick the base set from the candidate's size
    always_comb begin
        if (r_x < SMALL_LIMIT) begin
            set = SET_SMALL;
        end else if (r_x < MID_LIMIT) begin
            set = SET_MID;
        end else begin
            set = SET_LARGE;
        end
    end

    // steer multiplier operands
    always_comb begin
        case (i_cmd.mop)
            MOP_REDUCE: begin
                mul_a = XW'(1);
                mul_b = XW'(base_at(set, r_idx));
            end
            MOP_RB: begin
                mul_a = r_t;
                mul_b = r_b;
            end
            MOP_BB: begin
                mul_a = r_b;
                mul_b = r_b;
            end
            default: begin
                mul_a = r_t;
                mul_b = r_t;
            end
        endcase
    end

    mrt_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_x),
        .o_done  (mul_done),
        .o_r     (mul_r)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_candidate;
            r_xm1 <= i_candidate - 1'b1;
            r_d   <= i_candidate - 1'b1;
            r_s   <= '0;
            r_idx <= '0;
        end
        if (i_cmd.shift_d) begin
            r_d <= {1'b0, r_d[XW-1:1]};
            r_s <= r_s + 1'b1;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.k_init) begin
            r_k <= SW'(1);
        end
        if (i_cmd.mul_start) begin
            r_mop <= i_cmd.mop;
        end
        // write back the product by the operation that started it
        if (mul_done) begin
            case (r_mop)
                MOP_REDUCE: begin
                    r_b <= mul_r;
                    r_t <= XW'(1);
                    r_e <= r_d;
                end
                MOP_RB: begin
                    r_t <= mul_r;
                end
                MOP_BB: begin
                    r_b <= mul_r;
                    r_e <= {1'b0, r_e[XW-1:1]};
                end
                default: begin
                    r_t <= mul_r;
                    r_k <= r_k + 1'b1;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_out_prime <= i_cmd.out_val;
        end
    end

    // status towards the controller
    always_comb begin
        o_sts.below4    = (r_x < XW'(4));
        o_sts.gt1       = (r_x > XW'(1));
        o_sts.even      = ~r_x[0];
        o_sts.d_odd     = r_d[0];
        o_sts.b_zero    = (r_b == '0);
        o_sts.e_zero    = (r_e == '0);
        o_sts.e_lsb     = r_e[0];
        o_sts.t_pass    = (r_t == XW'(1)) || (r_t == r_xm1);
        o_sts.t_xm1     = (r_t == r_xm1);
        o_sts.t_le1     = (r_t <= XW'(1));
        o_sts.k_done    = (r_k >= r_s);
        o_sts.last_base = (r_idx == last_idx(set));
        o_sts.mul_done  = mul_done;
        o_sts.out_free  = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_prime     = r_out_prime;

endmodule

### rtl/mrt_ctrl.sv
// Controller of the prime tester: sequences classification, split, powering and squaring.
// Depends on mrt_pkg; drives mrt_dp by command word.
`timescale 1ns / 1ps

module mrt_ctrl import mrt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_CLASS  = 16'h0002,
        ST_SPLIT  = 16'h0004,
        ST_BASE   = 16'h0008,
        ST_WRED   = 16'h0010,
        ST_CHKB   = 16'h0020,
        ST_POW    = 16'h0040,
        ST_POWB   = 16'h0080,
        ST_WRB    = 16'h0100,
        ST_WBB    = 16'h0200,
        ST_TEST   = 16'h0400,
        ST_SQCHK  = 16'h0800,
        ST_WTT    = 16'h1000,
        ST_SQTEST = 16'h2000,
        ST_NEXT   = 16'h4000,
        ST_FINISH = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   r_res, n_res;

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.mop     = MOP_REDUCE;
        o_cmd.out_val = r_res;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CLASS;
                end
            end
            // settle trivial candidates at once
            ST_CLASS: begin
                if (i_sts.below4) begin
                    n_res   = i_sts.gt1;
                    n_state = ST_FINISH;
                end else if (i_sts.even) begin
                    n_res   = 1'b0;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SPLIT;
                end
            end
            // strip factors of two from x-1
            ST_SPLIT: begin
                if (i_sts.d_odd) begin
                    n_state = ST_BASE;
                end else begin
                    o_cmd.shift_d = 1'b1;
                end
            end
            ST_BASE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mop       = MOP_REDUCE;
                n_state         = ST_WRED;
            end
            ST_WRED: begin
                if (i_sts.mul_done) begin
                    n_state = ST_CHKB;
                end
            end
            ST_CHKB: begin
                n_state = i_sts.b_zero ? ST_NEXT : ST_POW;
            end
            // square-and-multiply over the exponent bits
            ST_POW: begin
                if (i_sts.e_zero) begin
                    n_state = ST_TEST;
                end else if (i_sts.e_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mop       = MOP_RB;
                    n_state         = ST_WRB;
                end else begin
                    n_state = ST_POWB;
                end
            end
            ST_WRB: begin
                if (i_sts.mul_done) begin
                    n_state = ST_POWB;
                end
            end
            ST_POWB: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mop       = MOP_BB;
                n_state         = ST_WBB;
            end
            ST_WBB: begin
                if (i_sts.mul_done) begin
                    n_state = ST_POW;
                end
            end
            ST_TEST: begin
                if (i_sts.t_pass) begin
                    n_state = ST_NEXT;
                end else begin
                    o_cmd.k_init = 1'b1;
                    n_state      = ST_SQCHK;
                end
            end
            // repeated squaring looking for x-1
            ST_SQCHK: begin
                if (i_sts.k_done) begin
                    n_res   = 1'b0;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mop       = MOP_TT;
                    n_state         = ST_WTT;
                end
            end
            ST_WTT: begin
                if (i_sts.mul_done) begin
                    n_state = ST_SQTEST;
                end
            end
            ST_SQTEST: begin
                if (i_sts.t_xm1) begin
                    n_state = ST_NEXT;
                end else if (i_sts.t_le1) begin
                    n_res   = 1'b0;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SQCHK;
                end
            end
            ST_NEXT: begin
                if (i_sts.last_base) begin
                    n_res   = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_BASE;
                end
            end
            // hand the verdict to the output register once it is free
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

### rtl/miller_rabin_prime_test_64.sv
// Deterministic Miller-Rabin prime test, top level: joins controller and datapath.
// Depends on mrt_pkg, mrt_if, mrt_ctrl and mrt_dp.
// One candidate is tested at a time. Candidates below four and even ones are settled
// without any modular product. Odd ones run through 2, 3 or 7 bases; every modular
// product goes through one shared bit-serial multiplier, and a base needs roughly
// popcount(d) + log2(d) + s products. A new candidate is taken as soon as the verdict
// has moved to the output register, even if that word is still waiting downstream.
`timescale 1ns / 1ps

module miller_rabin_prime_test_64 import mrt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrt_in_if.sink    i_in,
    mrt_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    mrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    mrt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_candidate (i_in.candidate),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_prime     (o_out.prime)
    );

    assign i_in.ready = in_ready;

endmodule

### rtl/mrt_checker.sv
// Port-level checker for the prime tester, bound to the top level.
// Depends on mrt_pkg for the candidate width.
`timescale 1ns / 1ps

module mrt_checker import mrt_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic [XW-1:0] i_candidate,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic          i_prime
);

    // hold a stalled verdict word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_prime))
        else $error("verdict word dropped or changed while stalled");

    // one candidate at a time: busy after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again while a test is running");

    // a fresh verdict only comes out of a running test
    a_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("verdict appeared while idle");

    // an even candidate above three keeps the input busy while it is settled
    a_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_candidate[0] && (i_candidate > XW'(3))
        |=> ##1 !i_in_ready)
        else $error("even candidate not processed");

endmodule

bind miller_rabin_prime_test_64 mrt_checker u_mrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_candidate (i_in.candidate),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_prime     (o_out.prime)
);
